// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion macros used by the checker file udp_hp_checker.sv.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// This assertion is checked at every rising clock edge outside of reset.
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// This assertion is checked at every rising clock edge, reset included.
`define ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("assertion failed");

`endif

// ===== design/udp_hp_pkg.sv =====
// ----------------------------------------------------------------------------
// udp_hp_pkg
// Types and constants of the Ethernet/IPv4/UDP header parser.
// ----------------------------------------------------------------------------
`default_nettype none

package udp_hp_pkg;

    localparam int MAX_FRAME_BYTES = 2048;
    localparam int COUNT_W         = $clog2(MAX_FRAME_BYTES + 1);

    localparam int MAC_W    = 48;
    localparam int IP_W     = 32;
    localparam int PORT_W   = 16;
    localparam int OFFSET_W = 7;
    localparam int PLEN_W   = 11;
    localparam int DIFF_W   = (COUNT_W > PLEN_W) ? COUNT_W : PLEN_W;

    localparam int ETH_HDR_BYTES   = 14;
    localparam int UDP_HDR_BYTES   = 8;
    localparam int MIN_FRAME_BYTES = 42;

    localparam int POS_SRC_MAC   = 6;
    localparam int POS_ETHERTYPE = 12;
    localparam int POS_IHL       = 14;
    localparam int POS_PROTOCOL  = 23;
    localparam int POS_SRC_IP    = 26;
    localparam int POS_DST_IP    = 30;
    localparam int POS_IP_END    = 34;

    localparam logic [15:0] IPV4_ETHERTYPE = 16'h0800;
    localparam logic [7:0]  UDP_PROTOCOL   = 8'd17;
    localparam logic [3:0]  MIN_IHL        = 4'd5;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_SHORT     = 3'd1,
        ST_NOT_IPV4  = 3'd2,
        ST_BAD_IHL   = 3'd3,
        ST_NOT_UDP   = 3'd4,
        ST_UDP_TRUNC = 3'd5
    } t_status;

    typedef struct packed {
        logic [COUNT_W-1:0] count;
        logic [15:0]        ether_type;
        logic [3:0]         header_words;
        logic [7:0]         ip_protocol;
        logic [MAC_W-1:0]   src_mac;
        logic [MAC_W-1:0]   dst_mac;
        logic [IP_W-1:0]    src_ip;
        logic [IP_W-1:0]    dst_ip;
        logic [31:0]        ports;
    } t_frame_state;

    typedef struct packed {
        t_status             status;
        logic [MAC_W-1:0]    source_mac;
        logic [MAC_W-1:0]    destination_mac;
        logic [IP_W-1:0]     source_ip;
        logic [IP_W-1:0]     destination_ip;
        logic [PORT_W-1:0]   source_port;
        logic [PORT_W-1:0]   destination_port;
        logic [OFFSET_W-1:0] payload_offset;
        logic [PLEN_W-1:0]   payload_length;
    } t_result;

endpackage

`default_nettype wire

// ===== design/udp_hp_capture.sv =====
// ----------------------------------------------------------------------------
// udp_hp_capture
// Per-frame byte counter and header field capture registers.
// ----------------------------------------------------------------------------
`default_nettype none

module udp_hp_capture (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_step,
    input  wire logic [7:0]              i_data_byte,
    input  wire logic                    i_last_byte,
    output udp_hp_pkg::t_frame_state     o_state
);
    import udp_hp_pkg::*;

    t_frame_state       r_state;
    t_frame_state       n_state;
    logic [6:0]         udp_start;
    logic [6:0]         udp_ports_end;
    logic [COUNT_W-1:0] pos;
    logic               in_ports;

    assign pos           = r_state.count;
    assign udp_start     = 7'(ETH_HDR_BYTES) + {1'b0, r_state.header_words, 2'b00};
    assign udp_ports_end = udp_start + 7'd4;
    assign in_ports      = (pos > COUNT_W'(POS_IHL)) && (pos >= COUNT_W'(udp_start))
                           && (pos < COUNT_W'(udp_ports_end));

    always_comb begin
        n_state = r_state;
        if (i_step) begin
            if (i_last_byte) begin
                n_state = '0;
            end else if (pos < COUNT_W'(MAX_FRAME_BYTES)) begin
                n_state.count = r_state.count + 1'b1;
                if (pos < COUNT_W'(POS_SRC_MAC)) begin
                    n_state.dst_mac = {r_state.dst_mac[MAC_W-9:0], i_data_byte};
                end else if (pos < COUNT_W'(POS_ETHERTYPE)) begin
                    n_state.src_mac = {r_state.src_mac[MAC_W-9:0], i_data_byte};
                end else if (pos < COUNT_W'(POS_IHL)) begin
                    n_state.ether_type = {r_state.ether_type[7:0], i_data_byte};
                end else if (pos == COUNT_W'(POS_IHL)) begin
                    n_state.header_words = i_data_byte[3:0];
                end else if (pos == COUNT_W'(POS_PROTOCOL)) begin
                    n_state.ip_protocol = i_data_byte;
                end else if (pos >= COUNT_W'(POS_SRC_IP) && pos < COUNT_W'(POS_DST_IP)) begin
                    n_state.src_ip = {r_state.src_ip[IP_W-9:0], i_data_byte};
                end else if (pos >= COUNT_W'(POS_DST_IP) && pos < COUNT_W'(POS_IP_END)) begin
                    n_state.dst_ip = {r_state.dst_ip[IP_W-9:0], i_data_byte};
                end
                if (in_ports) begin
                    n_state.ports = {r_state.ports[23:0], i_data_byte};
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_state = r_state;

endmodule

`default_nettype wire

// ===== design/udp_hp_check.sv =====
// ----------------------------------------------------------------------------
// udp_hp_check
// Frame validity checks and result formation on the final byte.
// ----------------------------------------------------------------------------
`default_nettype none

module udp_hp_check (
    input  wire udp_hp_pkg::t_frame_state i_state,
    output udp_hp_pkg::t_result           o_result
);
    import udp_hp_pkg::*;

    logic [COUNT_W-1:0] len;
    logic [6:0]         ip_end;
    logic [6:0]         hdr_end;
    logic [DIFF_W-1:0]  diff;
    t_status            status;

    // The final byte itself is counted unless the frame is already saturated.
    assign len     = (i_state.count < COUNT_W'(MAX_FRAME_BYTES)) ?
                     i_state.count + 1'b1 : i_state.count;
    assign ip_end  = 7'(ETH_HDR_BYTES) + {1'b0, i_state.header_words, 2'b00};
    assign hdr_end = ip_end + 7'(UDP_HDR_BYTES);
    assign diff    = DIFF_W'(len) - DIFF_W'(hdr_end);

    always_comb begin
        priority if (len < COUNT_W'(MIN_FRAME_BYTES)) begin
            status = ST_SHORT;
        end else if (i_state.ether_type != IPV4_ETHERTYPE) begin
            status = ST_NOT_IPV4;
        end else if (i_state.header_words < MIN_IHL || COUNT_W'(ip_end) > len) begin
            status = ST_BAD_IHL;
        end else if (i_state.ip_protocol != UDP_PROTOCOL) begin
            status = ST_NOT_UDP;
        end else if (COUNT_W'(hdr_end) > len) begin
            status = ST_UDP_TRUNC;
        end else begin
            status = ST_OK;
        end
    end

    always_comb begin
        o_result        = '0;
        o_result.status = status;
        if (status == ST_OK) begin
            o_result.source_mac       = i_state.src_mac;
            o_result.destination_mac  = i_state.dst_mac;
            o_result.source_ip        = i_state.src_ip;
            o_result.destination_ip   = i_state.dst_ip;
            o_result.source_port      = i_state.ports[31:16];
            o_result.destination_port = i_state.ports[15:0];
            o_result.payload_offset   = hdr_end;
            o_result.payload_length   = diff[PLEN_W-1:0];
        end
    end

endmodule

`default_nettype wire

// ===== design/udp_header_parser.sv =====
// ----------------------------------------------------------------------------
// udp_header_parser
// Ethernet/IPv4/UDP header parser, one frame byte per transaction.
// ----------------------------------------------------------------------------
// The input channel carries one frame byte per transaction in wire order,
// with i_last_byte set on the final byte of the frame. The output channel
// carries one result per frame: a status and the extracted header fields,
// all zero except the status when a check fails.
// The block takes one byte per cycle while the input is not stalled. A byte
// is held in the input register and then updates the capture registers. On
// a final byte the result is written to the output register, where it is
// offered to the receiver.
// While the receiver stalls, the held result stays on the output and bytes
// that produce no result keep flowing. A final byte waits in the input
// register until the output register frees, and input is stalled while it
// waits.
// Reset clears the capture registers and drops both valid flags.
// ----------------------------------------------------------------------------
`default_nettype none

module udp_header_parser (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_valid,
    output logic                                   o_stall,
    input  wire logic [7:0]                        i_data_byte,
    input  wire logic                              i_last_byte,
    output logic                                   o_valid,
    input  wire logic                              i_stall,
    output udp_hp_pkg::t_status                    o_status,
    output logic [udp_hp_pkg::MAC_W-1:0]           o_source_mac,
    output logic [udp_hp_pkg::MAC_W-1:0]           o_destination_mac,
    output logic [udp_hp_pkg::IP_W-1:0]            o_source_ip,
    output logic [udp_hp_pkg::IP_W-1:0]            o_destination_ip,
    output logic [udp_hp_pkg::PORT_W-1:0]          o_source_port,
    output logic [udp_hp_pkg::PORT_W-1:0]          o_destination_port,
    output logic [udp_hp_pkg::OFFSET_W-1:0]        o_payload_offset,
    output logic [udp_hp_pkg::PLEN_W-1:0]          o_payload_length
);
    import udp_hp_pkg::*;

    logic         r_in_valid;
    logic [7:0]   r_in_byte;
    logic         r_in_last;
    logic         r_out_valid;
    t_result      r_out;
    logic         out_free;
    logic         step;
    logic         in_accept;
    t_frame_state frame_state;
    t_result      result;

    assign out_free  = !r_out_valid || !i_stall;
    assign step      = r_in_valid && (!r_in_last || out_free);
    assign o_stall   = r_in_valid && !step;
    assign in_accept = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (step) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_byte <= i_data_byte;
            r_in_last <= i_last_byte;
        end
    end

    udp_hp_capture u_capture (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (step),
        .i_data_byte (r_in_byte),
        .i_last_byte (r_in_last),
        .o_state     (frame_state)
    );

    udp_hp_check u_check (
        .i_state  (frame_state),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step && r_in_last) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step && r_in_last) begin
            r_out <= result;
        end
    end

    assign o_valid            = r_out_valid;
    assign o_status           = r_out.status;
    assign o_source_mac       = r_out.source_mac;
    assign o_destination_mac  = r_out.destination_mac;
    assign o_source_ip        = r_out.source_ip;
    assign o_destination_ip   = r_out.destination_ip;
    assign o_source_port      = r_out.source_port;
    assign o_destination_port = r_out.destination_port;
    assign o_payload_offset   = r_out.payload_offset;
    assign o_payload_length   = r_out.payload_length;

endmodule

`default_nettype wire

// ===== design/udp_hp_checker.sv =====
// ----------------------------------------------------------------------------
// udp_hp_checker
// Port-level assertions for the header parser, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module udp_hp_checker (
    input wire logic                              i_clk,
    input wire logic                              i_rst_n,
    input wire logic                              o_valid,
    input wire logic                              i_stall,
    input wire udp_hp_pkg::t_status               o_status,
    input wire logic [udp_hp_pkg::MAC_W-1:0]      o_source_mac,
    input wire logic [udp_hp_pkg::MAC_W-1:0]      o_destination_mac,
    input wire logic [udp_hp_pkg::IP_W-1:0]       o_source_ip,
    input wire logic [udp_hp_pkg::IP_W-1:0]       o_destination_ip,
    input wire logic [udp_hp_pkg::PORT_W-1:0]     o_source_port,
    input wire logic [udp_hp_pkg::PORT_W-1:0]     o_destination_port,
    input wire logic [udp_hp_pkg::OFFSET_W-1:0]   o_payload_offset,
    input wire logic [udp_hp_pkg::PLEN_W-1:0]     o_payload_length
);
    import udp_hp_pkg::*;

    logic fields_zero;
    logic offset_ok;

    assign fields_zero = (o_source_mac == '0) && (o_destination_mac == '0)
                         && (o_source_ip == '0) && (o_destination_ip == '0)
                         && (o_source_port == '0) && (o_destination_port == '0)
                         && (o_payload_offset == '0) && (o_payload_length == '0);

    // A good frame has a header of at least five words and at most fifteen.
    assign offset_ok = (o_payload_offset >= OFFSET_W'(MIN_FRAME_BYTES))
                       && (o_payload_offset[1:0] == 2'b10);

    `ASSERT_CLK(a_out_hold, i_clk, i_rst_n, o_valid && i_stall |=> o_valid && $stable(o_status))
    `ASSERT_CLK(a_err_zero, i_clk, i_rst_n, o_valid && o_status != ST_OK |-> fields_zero)
    `ASSERT_CLK(a_ok_offset, i_clk, i_rst_n, o_valid && o_status == ST_OK |-> offset_ok)
    `ASSERT_ALWAYS(a_reset_idle, i_clk, !i_rst_n |=> !o_valid)

endmodule

bind udp_header_parser udp_hp_checker u_udp_hp_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .o_valid            (o_valid),
    .i_stall            (i_stall),
    .o_status           (o_status),
    .o_source_mac       (o_source_mac),
    .o_destination_mac  (o_destination_mac),
    .o_source_ip        (o_source_ip),
    .o_destination_ip   (o_destination_ip),
    .o_source_port      (o_source_port),
    .o_destination_port (o_destination_port),
    .o_payload_offset   (o_payload_offset),
    .o_payload_length   (o_payload_length)
);

`default_nettype wire

// ===== tb/udp_header_parser_tb.sv =====
// ----------------------------------------------------------------------------
// udp_header_parser_tb
// Self-checking testbench for the Ethernet/IPv4/UDP header parser.
// ----------------------------------------------------------------------------
// Frames are built from header fields and random filler bytes and sent one
// byte per transaction. A byte-level model of the parser runs on every
// accepted byte and queues the header result that each final byte should
// produce. Every result taken from the block is compared field by field with
// the oldest queued result. Directed frames cover each status, the header
// length limits, the ignored version nibble, all-zero and all-one fields
// and a long output hold. Random frames follow under three different sender
// and receiver idle patterns.
// ----------------------------------------------------------------------------
`default_nettype none

module udp_header_parser_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import udp_hp_pkg::*;

    localparam logic [7:0]  TCP_PROTOCOL   = 8'd6;
    localparam logic [15:0] IPV6_ETHERTYPE = 16'h86DD;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_valid;
    logic                o_stall;
    logic [7:0]          i_data_byte;
    logic                i_last_byte;
    logic                o_valid;
    logic                i_stall;
    t_status             o_status;
    logic [MAC_W-1:0]    o_source_mac;
    logic [MAC_W-1:0]    o_destination_mac;
    logic [IP_W-1:0]     o_source_ip;
    logic [IP_W-1:0]     o_destination_ip;
    logic [PORT_W-1:0]   o_source_port;
    logic [PORT_W-1:0]   o_destination_port;
    logic [OFFSET_W-1:0] o_payload_offset;
    logic [PLEN_W-1:0]   o_payload_length;

    udp_header_parser dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_stall            (o_stall),
        .i_data_byte        (i_data_byte),
        .i_last_byte        (i_last_byte),
        .o_valid            (o_valid),
        .i_stall            (i_stall),
        .o_status           (o_status),
        .o_source_mac       (o_source_mac),
        .o_destination_mac  (o_destination_mac),
        .o_source_ip        (o_source_ip),
        .o_destination_ip   (o_destination_ip),
        .o_source_port      (o_source_port),
        .o_destination_port (o_destination_port),
        .o_payload_offset   (o_payload_offset),
        .o_payload_length   (o_payload_length)
    );

    // Running copy of the parser's capture state.
    logic [11:0]      rx_count;
    logic [15:0]      rx_ethertype;
    logic [3:0]       rx_ihl;
    logic [7:0]       rx_protocol;
    logic [MAC_W-1:0] rx_src_mac;
    logic [MAC_W-1:0] rx_dst_mac;
    logic [IP_W-1:0]  rx_src_ip;
    logic [IP_W-1:0]  rx_dst_ip;
    logic [31:0]      rx_ports;

    t_result    expected_headers[$];
    logic [7:0] frame_buf[$];

    int send_idle_pct   = 0;
    int recv_idle_pct   = 0;
    int hold_off_cycles = 0;
    int bytes_sent      = 0;
    int frames_sent     = 0;
    int mismatch_count  = 0;
    int status_seen[6]  = '{default: 0};

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("%0t ns: run timed out", $time);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // The receiver stalls at random, or for a fixed stretch on request.
    initial begin
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_off_cycles > 0) begin
                i_stall <= 1'b1;
                hold_off_cycles--;
            end else begin
                i_stall <= ($urandom_range(99) < recv_idle_pct);
            end
        end
    end

    function automatic void clear_capture();
        rx_count     = '0;
        rx_ethertype = '0;
        rx_ihl       = '0;
        rx_protocol  = '0;
        rx_src_mac   = '0;
        rx_dst_mac   = '0;
        rx_src_ip    = '0;
        rx_dst_ip    = '0;
        rx_ports     = '0;
    endfunction

    function automatic void predict_header_byte(input logic [7:0] b, input logic last);
        int      pos;
        int      udp_start;
        int      flen;
        int      ip_end;
        int      hdr_end;
        t_result want;
        if (rx_count < MAX_FRAME_BYTES) begin
            pos       = rx_count;
            udp_start = ETH_HDR_BYTES + 4 * rx_ihl;
            if (pos < POS_SRC_MAC) begin
                rx_dst_mac = {rx_dst_mac[MAC_W-9:0], b};
            end else if (pos < POS_ETHERTYPE) begin
                rx_src_mac = {rx_src_mac[MAC_W-9:0], b};
            end else if (pos < POS_IHL) begin
                rx_ethertype = {rx_ethertype[7:0], b};
            end else if (pos == POS_IHL) begin
                rx_ihl = b[3:0];
            end else if (pos == POS_PROTOCOL) begin
                rx_protocol = b;
            end else if (pos >= POS_SRC_IP && pos < POS_DST_IP) begin
                rx_src_ip = {rx_src_ip[IP_W-9:0], b};
            end else if (pos >= POS_DST_IP && pos < POS_IP_END) begin
                rx_dst_ip = {rx_dst_ip[IP_W-9:0], b};
            end
            if (pos > POS_IHL && pos >= udp_start && pos < udp_start + 4) begin
                rx_ports = {rx_ports[23:0], b};
            end
            rx_count++;
        end
        if (!last) return;

        flen    = rx_count;
        ip_end  = ETH_HDR_BYTES + 4 * rx_ihl;
        hdr_end = ip_end + UDP_HDR_BYTES;
        want    = '0;
        if (flen < MIN_FRAME_BYTES) begin
            want.status = ST_SHORT;
        end else if (rx_ethertype != IPV4_ETHERTYPE) begin
            want.status = ST_NOT_IPV4;
        end else if (rx_ihl < MIN_IHL || ip_end > flen) begin
            want.status = ST_BAD_IHL;
        end else if (rx_protocol != UDP_PROTOCOL) begin
            want.status = ST_NOT_UDP;
        end else if (hdr_end > flen) begin
            want.status = ST_UDP_TRUNC;
        end else begin
            want.status           = ST_OK;
            want.source_mac       = rx_src_mac;
            want.destination_mac  = rx_dst_mac;
            want.source_ip        = rx_src_ip;
            want.destination_ip   = rx_dst_ip;
            want.source_port      = rx_ports[31:16];
            want.destination_port = rx_ports[15:0];
            want.payload_offset   = OFFSET_W'(hdr_end);
            want.payload_length   = PLEN_W'(flen - hdr_end);
        end
        expected_headers.push_back(want);
        frames_sent++;
        clear_capture();
    endfunction

    function automatic void compare_field(input string label, input logic [63:0] want,
                                          input logic [63:0] got);
        if (want !== got) begin
            $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h",
                     $time, label, want, got);
            mismatch_count++;
        end
    endfunction

    always @(posedge i_clk) begin : result_check
        t_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_headers.size() == 0) begin
                $display("%0t ns: unexpected result, actual status 0x%0h", $time, o_status);
                mismatch_count++;
            end else begin
                want = expected_headers.pop_front();
                status_seen[want.status]++;
                compare_field("status", want.status, o_status);
                compare_field("source_mac", want.source_mac, o_source_mac);
                compare_field("destination_mac", want.destination_mac, o_destination_mac);
                compare_field("source_ip", want.source_ip, o_source_ip);
                compare_field("destination_ip", want.destination_ip, o_destination_ip);
                compare_field("source_port", want.source_port, o_source_port);
                compare_field("destination_port", want.destination_port,
                              o_destination_port);
                compare_field("payload_offset", want.payload_offset, o_payload_offset);
                compare_field("payload_length", want.payload_length, o_payload_length);
            end
        end
    end

    function automatic logic [47:0] rand_mac();
        return {16'($urandom), 32'($urandom)};
    endfunction

    function automatic void place_field(input int pos, input logic [47:0] value,
                                        input int nbytes);
        for (int k = 0; k < nbytes; k++) begin
            if (pos + k < frame_buf.size()) begin
                frame_buf[pos + k] = value[8 * (nbytes - 1 - k) +: 8];
            end
        end
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_byte(input logic [7:0] b, input logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid     <= 1'b1;
        i_data_byte <= b;
        i_last_byte <= last;
        do @(posedge i_clk); while (o_stall);
        predict_header_byte(b, last);
        bytes_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_frame(input logic [47:0] dmac, input logic [47:0] smac,
                              input logic [15:0] etype, input logic [7:0] ver_ihl,
                              input logic [7:0] proto, input logic [31:0] sip,
                              input logic [31:0] dip, input logic [15:0] sport,
                              input logic [15:0] dport, input int len);
        int udp_at;
        udp_at = ETH_HDR_BYTES + 4 * ver_ihl[3:0];
        frame_buf.delete();
        repeat (len) frame_buf.push_back(8'($urandom));
        place_field(0, dmac, 6);
        place_field(POS_SRC_MAC, smac, 6);
        place_field(POS_ETHERTYPE, etype, 2);
        place_field(POS_IHL, ver_ihl, 1);
        place_field(POS_PROTOCOL, proto, 1);
        place_field(POS_SRC_IP, sip, 4);
        place_field(POS_DST_IP, dip, 4);
        if (ver_ihl[3:0] >= MIN_IHL) place_field(udp_at, {sport, dport}, 4);
        foreach (frame_buf[i]) send_byte(frame_buf[i], i == frame_buf.size() - 1);
    endtask

    task automatic send_udp(input logic [15:0] etype, input logic [7:0] ver_ihl,
                            input logic [7:0] proto, input int len);
        send_frame(rand_mac(), rand_mac(), etype, ver_ihl, proto, $urandom, $urandom,
                   16'($urandom), 16'($urandom), len);
    endtask

    task automatic test_short_frames();
        send_udp(IPV4_ETHERTYPE, 8'h45, UDP_PROTOCOL, 1);
        send_udp(IPV4_ETHERTYPE, 8'h45, UDP_PROTOCOL, 41);
        send_udp(IPV4_ETHERTYPE, 8'h45, UDP_PROTOCOL, 42);
    endtask

    task automatic test_ethertype();
        send_udp(16'h0008, 8'h45, UDP_PROTOCOL, 42);
        send_udp(IPV6_ETHERTYPE, 8'h45, UDP_PROTOCOL, 42);
        send_udp(16'h0801, 8'h45, UDP_PROTOCOL, 42);
    endtask

    task automatic test_header_length();
        send_udp(IPV4_ETHERTYPE, 8'h40, UDP_PROTOCOL, 42);
        send_udp(IPV4_ETHERTYPE, 8'h44, UDP_PROTOCOL, 42);
        send_udp(IPV4_ETHERTYPE, 8'h4F, UDP_PROTOCOL, 60);
        send_udp(IPV4_ETHERTYPE, 8'hF5, UDP_PROTOCOL, 50);
        send_udp(IPV4_ETHERTYPE, 8'h05, UDP_PROTOCOL, 50);
        send_udp(IPV4_ETHERTYPE, 8'h4F, UDP_PROTOCOL, 74);
    endtask

    task automatic test_protocol();
        send_udp(IPV4_ETHERTYPE, 8'h45, TCP_PROTOCOL, 42);
        send_udp(IPV4_ETHERTYPE, 8'h45, 8'h00, 42);
        send_udp(IPV4_ETHERTYPE, 8'h46, 8'hFF, 42);
    endtask

    task automatic test_udp_truncation();
        send_udp(IPV4_ETHERTYPE, 8'h46, UDP_PROTOCOL, 45);
        send_udp(IPV4_ETHERTYPE, 8'h4F, UDP_PROTOCOL, 81);
        send_udp(IPV4_ETHERTYPE, 8'h4F, UDP_PROTOCOL, 82);
    endtask

    task automatic test_field_extremes();
        send_frame('1, '1, IPV4_ETHERTYPE, 8'hFF, UDP_PROTOCOL, '1, '1, '1, '1, 82);
        send_frame('0, '0, IPV4_ETHERTYPE, 8'h05, UDP_PROTOCOL, '0, '0, '0, '0, 42);
    endtask

    // A long receiver hold lets results pile up until the input stalls.
    task automatic test_output_backpressure();
        hold_off_cycles = 300;
        send_udp(IPV4_ETHERTYPE, 8'h45, UDP_PROTOCOL, 42);
        send_udp(IPV4_ETHERTYPE, 8'h45, UDP_PROTOCOL, 1);
        send_udp(IPV4_ETHERTYPE, 8'h47, UDP_PROTOCOL, 56);
        send_udp(IPV4_ETHERTYPE, 8'h45, UDP_PROTOCOL, 1);
    endtask

    task automatic test_random_traffic(input int send_pct, input int recv_pct,
                                       input int min_bytes, input int min_frames);
        int          start_bytes;
        int          start_frames;
        int          ihl;
        int          hdr;
        int          len;
        int          pick;
        logic [15:0] etype;
        logic [7:0]  proto;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        start_bytes   = bytes_sent;
        start_frames  = frames_sent;
        while (bytes_sent - start_bytes < min_bytes ||
               frames_sent - start_frames < min_frames) begin
            ihl  = ($urandom_range(9) == 0) ? $urandom_range(4) : $urandom_range(15, 5);
            hdr  = ETH_HDR_BYTES + 4 * ihl + UDP_HDR_BYTES;
            pick = $urandom_range(9);
            if (pick == 0) begin
                len = $urandom_range(41, 1);
            end else if (pick == 1) begin
                len = $urandom_range(hdr - 1, hdr - 12);
            end else begin
                len = hdr + $urandom_range(24);
            end
            etype = ($urandom_range(9) == 0) ? 16'($urandom) : IPV4_ETHERTYPE;
            proto = ($urandom_range(9) == 0) ? 8'($urandom) : UDP_PROTOCOL;
            send_frame(rand_mac(), rand_mac(), etype, {4'($urandom), 4'(ihl)}, proto,
                       $urandom, $urandom, 16'($urandom), 16'($urandom), len);
        end
    endtask

    initial begin
        int drain_cycles;
        clear_capture();
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_data_byte = '0;
        i_last_byte = 1'b0;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        send_idle_pct = 24;
        recv_idle_pct = 74;
        test_short_frames();
        test_ethertype();
        test_header_length();
        test_protocol();
        test_udp_truncation();
        test_field_extremes();
        test_output_backpressure();
        test_random_traffic(24, 74, 60, 1);
        test_random_traffic(74, 24, 60, 1);
        test_random_traffic(0, 0, 60, 1);
        i_valid <= 1'b0;

        drain_cycles = 0;
        while (expected_headers.size() != 0 && drain_cycles < 50000) begin
            @(posedge i_clk);
            drain_cycles++;
        end
        repeat (8) @(posedge i_clk);
        if (expected_headers.size() != 0) begin
            $display("%0t ns: %0d expected results never arrived, expected 0, actual %0d",
                     $time, expected_headers.size(), expected_headers.size());
            mismatch_count++;
        end

        $display("Sent %0d frames in %0d bytes under three idle patterns and a long hold",
                 frames_sent, bytes_sent);
        $display("Results: ok %0d, short %0d, not IPv4 %0d, bad IHL %0d, not UDP %0d, %s %0d",
                 status_seen[ST_OK], status_seen[ST_SHORT], status_seen[ST_NOT_IPV4],
                 status_seen[ST_BAD_IHL], status_seen[ST_NOT_UDP], "UDP truncated",
                 status_seen[ST_UDP_TRUNC]);
        if (mismatch_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

`default_nettype wire
